### hw/rtl/nwsp_pkg.sv
package nwsp_pkg;

   localparam int FIELD_CHARS = 5;

   localparam int BYTE_W   = 8;
   localparam int GAIN_W   = 17;
   localparam int DIR_W    = 28;
   localparam int SPD_W    = 27;
   localparam int POS_W    = 5;
   localparam int MANT_W   = 17;
   localparam int FRAC_W   = 2;
   localparam int FLAG_W   = 4;
   localparam int OPA_W    = 27;
   localparam int OPB_W    = 17;
   localparam int ADD_W    = 16;
   localparam int PROD_W   = OPA_W + OPB_W;

   localparam logic [GAIN_W-1:0] GAIN_RESET = GAIN_W'(33715);

   localparam logic [POS_W-1:0] POS_MAX    = POS_W'(20);
   localparam logic [POS_W-1:0] PREFIX_LEN = POS_W'(6);
   localparam logic [POS_W-1:0] DIR_START  = POS_W'(7);
   localparam logic [POS_W-1:0] SPD_START  = POS_W'(15);
   localparam logic [POS_W:0]   DIR_END    = (POS_W+1)'(7 + FIELD_CHARS);
   localparam logic [POS_W:0]   SPD_END    = (POS_W+1)'(15 + FIELD_CHARS);

   localparam logic [MANT_W-1:0] MANT_MAX  = MANT_W'(131071);
   localparam logic [OPA_W-1:0]  MILLI_MAX = OPA_W'(99999000);
   localparam logic [DIR_W-1:0]  SPD_POS_MAX = DIR_W'(67108863);
   localparam logic [DIR_W-1:0]  SPD_NEG_MAX = DIR_W'(67108864);
   localparam logic [FRAC_W-1:0] FRAC_MAX  = FRAC_W'(3);

   localparam logic [BYTE_W-1:0] CHAR_NL    = 8'h0A;
   localparam logic [BYTE_W-1:0] CHAR_TAB   = 8'h09;
   localparam logic [BYTE_W-1:0] CHAR_VT    = 8'h0B;
   localparam logic [BYTE_W-1:0] CHAR_FF    = 8'h0C;
   localparam logic [BYTE_W-1:0] CHAR_CR    = 8'h0D;
   localparam logic [BYTE_W-1:0] CHAR_SPACE = 8'h20;
   localparam logic [BYTE_W-1:0] CHAR_PLUS  = 8'h2B;
   localparam logic [BYTE_W-1:0] CHAR_MINUS = 8'h2D;
   localparam logic [BYTE_W-1:0] CHAR_POINT = 8'h2E;
   localparam logic [BYTE_W-1:0] CHAR_ZERO  = 8'h30;
   localparam logic [BYTE_W-1:0] CHAR_NINE  = 8'h39;

   localparam int FL_STARTED = 0;
   localparam int FL_NEG     = 1;
   localparam int FL_POINT   = 2;
   localparam int FL_STOP    = 3;

   typedef struct packed {
      logic [MANT_W-1:0] digits;
      logic [FRAC_W-1:0] frac;
      logic [FLAG_W-1:0] flags;
   } field_type;

   typedef struct packed {
      logic [FLAG_W-1:0] flags;
      logic              push;
      logic              frac_inc;
   } step_type;

   typedef struct packed {
      logic [OPA_W-1:0] op_a;
      logic [OPB_W-1:0] op_b;
      logic [ADD_W-1:0] op_add;
   } mul_req_type;

   function automatic logic [BYTE_W-1:0] head_char(input logic [POS_W-1:0] pos);
      logic [BYTE_W-1:0] c;
      unique case (pos)
         POS_W'(0): c = 8'h24;
         POS_W'(1): c = 8'h49;
         POS_W'(2): c = 8'h49;
         POS_W'(3): c = 8'h4D;
         POS_W'(4): c = 8'h57;
         POS_W'(5): c = 8'h56;
         default:   c = 8'h00;
      endcase
      return c;
   endfunction

   function automatic logic [OPB_W-1:0] pow10_scale(input logic [FRAC_W-1:0] frac);
      logic [OPB_W-1:0] s;
      unique case (frac)
         FRAC_W'(0): s = OPB_W'(1000);
         FRAC_W'(1): s = OPB_W'(100);
         FRAC_W'(2): s = OPB_W'(10);
         default:    s = OPB_W'(1);
      endcase
      return s;
   endfunction

   // Decides what one character does to a number field, in the manner of atof.
   function automatic step_type parse_step(input field_type f, input logic [BYTE_W-1:0] c);
      step_type s;
      logic     is_ws;
      logic     is_digit;
      s.flags    = f.flags;
      s.push     = 1'b0;
      s.frac_inc = 1'b0;
      is_ws = (c == CHAR_SPACE) || (c == CHAR_TAB) || (c == CHAR_CR) ||
              (c == CHAR_VT) || (c == CHAR_FF);
      is_digit = (c >= CHAR_ZERO) && (c <= CHAR_NINE);
      priority if (f.flags[FL_STOP]) begin
         s.flags = f.flags;
      end else if (!f.flags[FL_STARTED] && is_ws) begin
         s.flags = f.flags;
      end else if (!f.flags[FL_STARTED] && (c == CHAR_PLUS || c == CHAR_MINUS)) begin
         s.flags[FL_STARTED] = 1'b1;
         if (c == CHAR_MINUS) begin
            s.flags[FL_NEG] = 1'b1;
         end
      end else if (is_digit) begin
         s.flags[FL_STARTED] = 1'b1;
         if (!f.flags[FL_POINT]) begin
            s.push = 1'b1;
         end else if (f.frac != FRAC_MAX) begin
            s.push     = 1'b1;
            s.frac_inc = 1'b1;
         end
      end else if (c == CHAR_POINT && !f.flags[FL_POINT]) begin
         s.flags[FL_STARTED] = 1'b1;
         s.flags[FL_POINT]   = 1'b1;
      end else begin
         s.flags[FL_STOP] = 1'b1;
      end
      return s;
   endfunction

endpackage

### hw/rtl/nwsp_req_if.sv
interface nwsp_req_if;
   import nwsp_pkg::*;

   logic              valid;
   logic              ready;
   logic [BYTE_W-1:0] rx_byte;

   modport source (output valid, output rx_byte, input ready);
   modport sink (input valid, input rx_byte, output ready);
endinterface

### hw/rtl/nwsp_rsp_if.sv
interface nwsp_rsp_if;
   import nwsp_pkg::*;

   logic                    valid;
   logic                    ready;
   logic signed [DIR_W-1:0] wind_direction_milli;
   logic signed [SPD_W-1:0] wind_speed_mm_s;

   modport source (output valid, output wind_direction_milli, output wind_speed_mm_s,
                   input ready);
   modport sink (input valid, input wind_direction_milli, input wind_speed_mm_s,
                 output ready);
endinterface

### hw/rtl/nwsp_mul_unit.sv
module nwsp_mul_unit (
   input  logic                          clock,
   input  nwsp_pkg::mul_req_type         mul_req,
   output logic [nwsp_pkg::PROD_W-1:0]   product_ff
);
   import nwsp_pkg::*;

   logic [PROD_W-1:0] product_in;

   // Multiply-add shared by digit accumulation, decimal scaling and the gain.
   assign product_in = (PROD_W'(mul_req.op_a) * PROD_W'(mul_req.op_b)) +
                       PROD_W'(mul_req.op_add);

   always_ff @(posedge clock) begin
      product_ff <= product_in;
   end

endmodule

### hw/rtl/nmea_wind_sentence_parser_top.sv
// MWV wind sentence parser.
// req_chan carries one received UART character per transaction (rx_byte).
// rsp_chan carries one result per newline that ends a line starting with
// $IIMWV: the direction in thousandths of a degree and the speed in mm/s.
// csr_we/csr_wdata load the unsigned Q16 knots-to-m/s gain at any edge.
// An ordinary character passes through ST_IDLE, where it is taken, ST_CHAR, in
// which the shared multiply-add unit forms digits*10+digit, and the write-back
// state ST_CHAR_WB. A newline that produces a result goes through ST_DIR_SCALE,
// ST_SPD_SCALE, ST_SPD_SAT, ST_GAIN and ST_FINISH before rsp_chan.valid rises:
// the same unit scales direction and speed to thousandths, then applies the
// gain, one multiply per cycle with a saturation step between. A newline with no
// result is handled in ST_IDLE. req_chan.ready is high only while the sequencer is idle.
// The result sits in an output register; further characters are taken while
// it waits, and only the next result-producing newline stalls until the
// receiver takes the pending one.
// Reset is synchronous: it clears the line state, drops rsp_chan.valid and
// restores the gain to its default of 33715.
module nmea_wind_sentence_parser_top (
   input  logic                          clock,
   input  logic                          reset,
   nwsp_req_if.sink                      req_chan,
   nwsp_rsp_if.source                    rsp_chan,
   input  logic                          csr_we,
   input  logic [nwsp_pkg::GAIN_W-1:0]   csr_wdata
);
   import nwsp_pkg::*;

   localparam logic [2:0] ST_IDLE      = 3'd0;
   localparam logic [2:0] ST_CHAR      = 3'd1;
   localparam logic [2:0] ST_CHAR_WB   = 3'd2;
   localparam logic [2:0] ST_DIR_SCALE = 3'd3;
   localparam logic [2:0] ST_SPD_SCALE = 3'd4;
   localparam logic [2:0] ST_SPD_SAT   = 3'd5;
   localparam logic [2:0] ST_GAIN      = 3'd6;
   localparam logic [2:0] ST_FINISH    = 3'd7;

   logic [2:0]              state_ff, state_in;
   logic [GAIN_W-1:0]       gain_ff, gain_in;
   logic [BYTE_W-1:0]       byte_ff, byte_in;
   logic [POS_W-1:0]        pos_ff, pos_in;
   logic                    prefix_ff, prefix_in;
   field_type               dir_ff, dir_in;
   field_type               spd_ff, spd_in;
   logic [DIR_W-1:0]        dir_out_ff, dir_out_in;
   logic [OPA_W-1:0]        spd_mag_ff, spd_mag_in;
   logic                    rsp_valid_ff, rsp_valid_in;
   logic [DIR_W-1:0]        rsp_dir_ff, rsp_dir_in;
   logic [SPD_W-1:0]        rsp_spd_ff, rsp_spd_in;

   mul_req_type             mul_req;
   logic [PROD_W-1:0]       product_ff;

   logic                    accept;
   logic                    in_dir, in_spd;
   field_type               act_field;
   step_type                step;
   field_type               upd_field;
   logic [OPA_W-1:0]        scaled_mag;
   logic [DIR_W-1:0]        gain_q;
   logic [DIR_W-1:0]        gain_sat;
   logic [BYTE_W-1:0]       digit_val;
   logic                    out_free;

   nwsp_mul_unit u_mul (
      .clock      (clock),
      .mul_req    (mul_req),
      .product_ff (product_ff)
   );

   assign req_chan.ready = (state_ff == ST_IDLE);
   assign accept = req_chan.valid && req_chan.ready;

   assign rsp_chan.valid                = rsp_valid_ff;
   assign rsp_chan.wind_direction_milli = rsp_dir_ff;
   assign rsp_chan.wind_speed_mm_s      = rsp_spd_ff;

   assign out_free = !rsp_valid_ff || rsp_chan.ready;

   assign in_dir = ({1'b0, pos_ff} >= {1'b0, DIR_START}) && ({1'b0, pos_ff} < DIR_END);
   assign in_spd = ({1'b0, pos_ff} >= {1'b0, SPD_START}) && ({1'b0, pos_ff} < SPD_END) &&
                   (pos_ff < POS_MAX);
   assign act_field = in_spd ? spd_ff : dir_ff;
   assign digit_val = byte_ff - CHAR_ZERO;
   assign step = parse_step(act_field, byte_ff);

   // Saturated magnitude of a decimal-scaled mantissa.
   assign scaled_mag = (product_ff > PROD_W'(MILLI_MAX)) ? MILLI_MAX : product_ff[OPA_W-1:0];

   // Product of the gain, already rounded toward minus infinity for negatives.
   assign gain_q = product_ff[PROD_W-1:PROD_W-DIR_W];
   always_comb begin
      if (spd_ff.flags[FL_NEG]) begin
         gain_sat = (gain_q > SPD_NEG_MAX) ? SPD_NEG_MAX : gain_q;
         gain_sat = DIR_W'(0) - gain_sat;
      end else begin
         gain_sat = (gain_q > SPD_POS_MAX) ? SPD_POS_MAX : gain_q;
      end
   end

   always_comb begin
      mul_req = '0;
      unique case (state_ff)
         ST_CHAR: begin
            mul_req.op_a   = OPA_W'(act_field.digits);
            mul_req.op_b   = OPB_W'(10);
            mul_req.op_add = ADD_W'(digit_val[3:0]);
         end
         ST_DIR_SCALE: begin
            mul_req.op_a = OPA_W'(dir_ff.digits);
            mul_req.op_b = pow10_scale(dir_ff.frac);
         end
         ST_SPD_SCALE: begin
            mul_req.op_a = OPA_W'(spd_ff.digits);
            mul_req.op_b = pow10_scale(spd_ff.frac);
         end
         ST_GAIN, ST_FINISH: begin
            mul_req.op_a   = spd_mag_ff;
            mul_req.op_b   = gain_ff;
            mul_req.op_add = spd_ff.flags[FL_NEG] ? {ADD_W{1'b1}} : ADD_W'(0);
         end
         default: begin
            mul_req = '0;
         end
      endcase
   end

   always_comb begin
      upd_field = act_field;
      upd_field.flags = step.flags;
      if (step.push) begin
         upd_field.digits = (product_ff > PROD_W'(MANT_MAX)) ? MANT_MAX :
                            product_ff[MANT_W-1:0];
      end
      if (step.frac_inc) begin
         upd_field.frac = act_field.frac + FRAC_W'(1);
      end
   end

   always_comb begin
      state_in     = state_ff;
      gain_in      = csr_we ? csr_wdata : gain_ff;
      byte_in      = byte_ff;
      pos_in       = pos_ff;
      prefix_in    = prefix_ff;
      dir_in       = dir_ff;
      spd_in       = spd_ff;
      dir_out_in   = dir_out_ff;
      spd_mag_in   = spd_mag_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_chan.ready;
      rsp_dir_in   = rsp_dir_ff;
      rsp_spd_in   = rsp_spd_ff;

      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               byte_in = req_chan.rx_byte;
               if (req_chan.rx_byte != CHAR_NL) begin
                  state_in = ST_CHAR;
               end else if (prefix_ff && pos_ff >= PREFIX_LEN) begin
                  state_in = ST_DIR_SCALE;
               end else begin
                  pos_in    = '0;
                  prefix_in = 1'b1;
                  dir_in    = '0;
                  spd_in    = '0;
               end
            end
         end
         ST_CHAR: begin
            state_in = ST_CHAR_WB;
         end
         ST_CHAR_WB: begin
            if (pos_ff < PREFIX_LEN && byte_ff != head_char(pos_ff)) begin
               prefix_in = 1'b0;
            end
            if (pos_ff < POS_MAX) begin
               if (in_dir) begin
                  dir_in = upd_field;
               end
               if (in_spd) begin
                  spd_in = upd_field;
               end
               pos_in = pos_ff + POS_W'(1);
            end
            state_in = ST_IDLE;
         end
         ST_DIR_SCALE: begin
            state_in = ST_SPD_SCALE;
         end
         ST_SPD_SCALE: begin
            dir_out_in = dir_ff.flags[FL_NEG] ? (DIR_W'(0) - DIR_W'(scaled_mag)) :
                         DIR_W'(scaled_mag);
            state_in = ST_SPD_SAT;
         end
         ST_SPD_SAT: begin
            spd_mag_in = scaled_mag;
            state_in   = ST_GAIN;
         end
         ST_GAIN: begin
            state_in = ST_FINISH;
         end
         ST_FINISH: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_dir_in   = dir_out_ff;
               rsp_spd_in   = gain_sat[SPD_W-1:0];
               pos_in       = '0;
               prefix_in    = 1'b1;
               dir_in       = '0;
               spd_in       = '0;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         gain_ff      <= GAIN_RESET;
         pos_ff       <= '0;
         prefix_ff    <= 1'b1;
         dir_ff       <= '0;
         spd_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         gain_ff      <= gain_in;
         pos_ff       <= pos_in;
         prefix_ff    <= prefix_in;
         dir_ff       <= dir_in;
         spd_ff       <= spd_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      byte_ff    <= byte_in;
      dir_out_ff <= dir_out_in;
      spd_mag_ff <= spd_mag_in;
      rsp_dir_ff <= rsp_dir_in;
      rsp_spd_ff <= rsp_spd_in;
   end

endmodule
